[hdl/sitda_pkg.sv]
// shared constants, command/status types and the double-dabble step for
// signed_int_to_decimal_ascii; no dependencies
package sitda_pkg;

   // width of the signed input value
   localparam int VALUE_BITS  = 32;
   // magnitude bits consumed by the datapath per conversion cycle
   localparam int STEP_BITS   = 4;
   localparam int PAD_BITS    = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int STEP_COUNT  = PAD_BITS / STEP_BITS;
   localparam int STEP_W      = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
   // decimal digits of the largest magnitude (1233/4096 ~ log10 2)
   localparam int DIGIT_COUNT = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS    = DIGIT_COUNT * 4;
   localparam int IDX_W       = $clog2(DIGIT_COUNT);
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int CHAR_BITS   = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture value, clear bcd
      logic step;       // advance conversion by STEP_BITS bits
      logic find;       // locate leading digit
      logic emit_next;  // move to next lower digit
      logic sign_sel;   // present '-' instead of a digit
   } sitda_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;  // this step is the final one
      logic negative;
      logic last_digit; // digit pointer at units
   } sitda_status_type;

   // one double-dabble bit: add 3 to every digit of 5 or more, then shift in
   function automatic logic [BCD_BITS-1:0] dabble(input logic [BCD_BITS-1:0] bcd,
                                                   input logic bit_in);
      logic [BCD_BITS-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (adj[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
         end
      end
      return {adj[BCD_BITS-2:0], bit_in};
   endfunction

endpackage

[hdl/sitda_dp.sv]
// datapath: magnitude shift register, bcd accumulator and digit pointer
// depends on sitda_pkg
module sitda_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sitda_pkg::sitda_cmd_type            cmd,
   output sitda_pkg::sitda_status_type         status,
   input  logic [sitda_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic [sitda_pkg::CHAR_BITS-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   logic [sitda_pkg::VALUE_BITS-1:0] raw;
   logic [sitda_pkg::VALUE_BITS-1:0] magn;
   logic                             raw_neg;

   logic [sitda_pkg::PAD_BITS-1:0]   mag_ff, mag_in, mag_step;
   logic [sitda_pkg::BCD_BITS-1:0]   bcd_ff, bcd_in, bcd_step;
   logic                             neg_ff, neg_in;
   logic [sitda_pkg::STEP_W-1:0]     step_cnt_ff, step_cnt_in;
   logic [sitda_pkg::IDX_W-1:0]      idx_ff, idx_in, lead_idx;
   logic [3:0]                       digit;

   assign raw     = req_tdata[sitda_pkg::VALUE_BITS-1:0];
   assign raw_neg = raw[sitda_pkg::VALUE_BITS-1];
   // unsigned negate also covers the most negative value
   assign magn    = raw_neg ? (~raw + 1'b1) : raw;

   // STEP_BITS dependent dabble steps per cycle
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < sitda_pkg::STEP_BITS; s++) begin
         bcd_step = sitda_pkg::dabble(bcd_step, mag_step[sitda_pkg::PAD_BITS-1]);
         mag_step = {mag_step[sitda_pkg::PAD_BITS-2:0], 1'b0};
      end
   end

   // highest nonzero digit, units when all zero
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < sitda_pkg::DIGIT_COUNT; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead_idx = sitda_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      step_cnt_in = step_cnt_ff;
      idx_in      = idx_ff;
      if (cmd.load) begin
         mag_in      = sitda_pkg::PAD_BITS'(magn);
         bcd_in      = '0;
         neg_in      = raw_neg;
         step_cnt_in = '0;
      end else if (cmd.step) begin
         mag_in      = mag_step;
         bcd_in      = bcd_step;
         step_cnt_in = step_cnt_ff + 1'b1;
      end else if (cmd.find) begin
         idx_in      = lead_idx;
      end else if (cmd.emit_next) begin
         idx_in      = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cnt_ff <= '0;
      end else begin
         step_cnt_ff <= step_cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      idx_ff <= idx_in;
   end

   assign digit = bcd_ff[idx_ff*4 +: 4];

   assign status.conv_done  = (step_cnt_ff == sitda_pkg::STEP_W'(sitda_pkg::STEP_COUNT - 1));
   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);

   assign rsp_tdata = cmd.sign_sel ? sitda_pkg::CHAR_MINUS
                                   : (sitda_pkg::CHAR_ZERO + {4'b0000, digit});
   assign rsp_tlast = !cmd.sign_sel && (idx_ff == '0);

endmodule

[hdl/sitda_ctrl.sv]
// controller state machine: input handshake, conversion sequencing, emission
// depends on sitda_pkg
module sitda_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output sitda_pkg::sitda_cmd_type    cmd,
   input  sitda_pkg::sitda_status_type status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_LEAD = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.sign_sel  = (state_ff == ST_SIGN);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            cmd.find = 1'b1;
            state_in = status.negative ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (rsp_tready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/signed_int_to_decimal_ascii.sv]
// one signed value in, its decimal ascii text out one character per transfer
// text of 1 to 11 characters; the next value is accepted only after the last character is taken
// first character is valid once the conversion steps, STEP_BITS = 4 bits each,
// and the leading-digit step have run
// synchronous active-high reset returns the controller to idle, no output pending
// depends on sitda_pkg, sitda_ctrl, sitda_dp
module signed_int_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sitda_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [31:0] value (signed)
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sitda_pkg::CHAR_BITS-1:0]     rsp_tdata,  // [7:0] text_char
   output logic                                rsp_tlast   // last_char
);

   // command and status between controller and datapath
   sitda_pkg::sitda_cmd_type    cmd;
   sitda_pkg::sitda_status_type status;

   // controller: one value at a time, accepts only when idle
   sitda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: shift-and-add-3 binary to bcd, then digit pointer walks down
   // from the leading nonzero digit, or units for zero; character held stable while stalled
   sitda_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

[hdl/sitda_chk.sv]
// port-level checker for signed_int_to_decimal_ascii, bound to the top level
// depends on sitda_pkg
module sitda_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sitda_pkg::CHAR_BITS-1:0]     rsp_tdata,
   input logic                                rsp_tlast
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // never takes a new value while characters are still offered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result pending");

   // an input transfer starts conversion: no ready, no result next cycle
   a_conv_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("conversion did not start");

   // the final character ends the text: back to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("output continued after last character");

   // last character is always a digit
   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata != sitda_pkg::CHAR_MINUS)
      else $error("sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
